[hdl/sket_pkg.sv]
// ----------------------------------------------------------------------------
// sket_pkg
// Shared types and constants for the skyline edge table.
// ----------------------------------------------------------------------------
package sket_pkg;

    localparam int MAX_EDGES_DEF   = 64;
    localparam int COORD_BITS_DEF  = 32;
    localparam int HEIGHT_BITS_DEF = 16;
    localparam int INDEX_BITS      = 6;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RDWAIT,
        S_SCAN,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic rdwait;
        logic step;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic add_go;
        logic scan_end;
    } t_stat;

endpackage

[hdl/sket_ctrl.sv]
// ----------------------------------------------------------------------------
// sket_ctrl
// Sequencer: accept, memory read wait, merge scan, result hand-off.
// ----------------------------------------------------------------------------
module sket_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_free,
    input  sket_pkg::t_stat i_stat,
    output sket_pkg::t_cmd  o_cmd
);

    sket_pkg::t_state r_state;
    sket_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sket_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sket_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = sket_pkg::S_RDWAIT;
                end
            end
            sket_pkg::S_RDWAIT: begin
                n_state = i_stat.add_go ? sket_pkg::S_SCAN : sket_pkg::S_DONE;
            end
            sket_pkg::S_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = sket_pkg::S_DONE;
                end
            end
            sket_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = sket_pkg::S_IDLE;
                end
            end
            default: n_state = sket_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        unique case (r_state)
            sket_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            sket_pkg::S_RDWAIT: o_cmd.rdwait = 1'b1;
            sket_pkg::S_SCAN:   o_cmd.step   = !i_stat.scan_end;
            sket_pkg::S_DONE:   o_cmd.finish = i_out_free;
            default: o_cmd = '0;
        endcase
    end

    // only one command at a time
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd)) else $error("sket_ctrl: overlapping commands");
    // a load always leads to the read wait
    a_load_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.rdwait) else $error("sket_ctrl: load not followed by read");
    // finish leaves the block ready for the next item
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> o_in_ready) else $error("sket_ctrl: not idle after finish");

endmodule

[hdl/sket_dp.sv]
// ----------------------------------------------------------------------------
// sket_dp
// Edge store (two banks) and merge datapath. Each scan step reads the old
// bank in order and writes the merged table into the other bank.
// ----------------------------------------------------------------------------
module sket_dp #(
    parameter int MAX_EDGES   = sket_pkg::MAX_EDGES_DEF,
    parameter int COORD_BITS  = sket_pkg::COORD_BITS_DEF,
    parameter int HEIGHT_BITS = sket_pkg::HEIGHT_BITS_DEF,
    localparam int AW   = $clog2(MAX_EDGES),
    localparam int CW   = $clog2(MAX_EDGES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sket_pkg::t_cmd                i_cmd,
    output sket_pkg::t_stat               o_stat,
    input  logic [1:0]                    i_mode,
    input  logic signed [COORD_BITS-1:0]  i_left_x,
    input  logic signed [COORD_BITS-1:0]  i_right_x,
    input  logic [HEIGHT_BITS-1:0]        i_height,
    input  logic [sket_pkg::INDEX_BITS-1:0] i_index,
    output logic signed [COORD_BITS-1:0]  o_res_pos,
    output logic [HEIGHT_BITS-1:0]        o_res_height,
    output logic [CW-1:0]                 o_res_count,
    output logic [1:0]                    o_res_status
);

    localparam int CMPW  = (CW > sket_pkg::INDEX_BITS) ? CW : sket_pkg::INDEX_BITS;
    localparam int DEPTH = 2 ** (AW + 1);

    logic signed [COORD_BITS-1:0] mem_pos [DEPTH];
    logic [HEIGHT_BITS-1:0]       mem_hgt [DEPTH];

    logic [1:0]                   r_mode;
    logic signed [COORD_BITS-1:0] r_x1, r_x2;
    logic [HEIGHT_BITS-1:0]       r_h;
    logic [sket_pkg::INDEX_BITS-1:0] r_index;
    logic [CW-1:0]                r_count;
    logic                         r_bank;
    logic [CW-1:0]                r_k, n_k;
    logic [CW:0]                  r_w, n_w;
    logic [1:0]                   r_ins, n_ins;
    logic                         r_left_done, n_left_done;
    logic                         r_right_done, n_right_done;
    logic                         r_inreg, n_inreg;
    logic [HEIGHT_BITS-1:0]       r_prevh, n_prevh;
    logic [HEIGHT_BITS-1:0]       r_lasth, n_lasth;
    logic                         r_have_last, n_have_last;
    logic signed [COORD_BITS-1:0] r_rd_pos;
    logic [HEIGHT_BITS-1:0]       r_rd_hgt;

    logic                         cur_end, consume, emit;
    logic signed [COORD_BITS-1:0] e_pos;
    logic [HEIGHT_BITS-1:0]       e_hgt, hmax;
    logic [CW-1:0]                k_inc;
    logic [AW:0]                  rd_addr, wr_addr;
    logic [CMPW-1:0]              idx_ext;
    logic                         idx_ok, fits;

    assign cur_end = (r_k == r_count);
    assign hmax    = (r_rd_hgt > r_h) ? r_rd_hgt : r_h;
    assign k_inc   = r_k + 1'b1;
    assign idx_ext = CMPW'(r_index);
    assign idx_ok  = idx_ext < CMPW'(r_count);
    assign fits    = ((CW+1)'(r_count) + (CW+1)'(r_ins)) <= (CW+1)'(MAX_EDGES);

    assign o_stat.add_go   = (r_mode == sket_pkg::MODE_ADD) && (r_x1 < r_x2) && (r_h != '0);
    assign o_stat.scan_end = r_left_done && r_right_done && cur_end;

    // one merge step
    always_comb begin
        consume      = 1'b0;
        emit         = 1'b0;
        e_pos        = r_rd_pos;
        e_hgt        = r_rd_hgt;
        n_left_done  = r_left_done;
        n_right_done = r_right_done;
        n_inreg      = r_inreg;
        n_prevh      = r_prevh;
        n_ins        = r_ins;
        if (!r_left_done && (cur_end || r_rd_pos >= r_x1)) begin
            n_left_done = 1'b1;
            n_inreg     = 1'b1;
            if (!cur_end && r_rd_pos == r_x1) begin
                emit    = 1'b1;
                consume = 1'b1;
                e_hgt   = hmax;
                n_prevh = hmax;
            end else if (!r_have_last || r_h > r_lasth) begin
                emit    = 1'b1;
                e_pos   = r_x1;
                e_hgt   = r_h;
                n_prevh = r_h;
                n_ins   = r_ins + 1'b1;
            end else begin
                // region opens at the edge already written
                n_prevh = r_lasth;
            end
        end else if (r_left_done && !r_right_done && (cur_end || r_rd_pos >= r_x2)) begin
            n_right_done = 1'b1;
            n_inreg      = 1'b0;
            if (!cur_end && r_rd_pos == r_x2) begin
                emit = 1'b0;
            end else if (cur_end || !r_have_last) begin
                emit  = 1'b1;
                e_pos = r_x2;
                e_hgt = '0;
                n_ins = r_ins + 1'b1;
            end else if (r_h > r_lasth) begin
                emit  = 1'b1;
                e_pos = r_x2;
                e_hgt = r_lasth;
                n_ins = r_ins + 1'b1;
            end
        end else if (!cur_end) begin
            consume = 1'b1;
            if (r_inreg) begin
                if (hmax != r_prevh) begin
                    emit    = 1'b1;
                    e_hgt   = hmax;
                    n_prevh = hmax;
                end
            end else begin
                emit = 1'b1;
            end
        end
        n_k         = consume ? k_inc : r_k;
        n_lasth     = consume ? r_rd_hgt : r_lasth;
        n_have_last = r_have_last | consume;
        n_w         = emit ? r_w + 1'b1 : r_w;
    end

    // a read item keeps its entry addressed so a stalled result holds its data
    always_comb begin
        if (i_cmd.rdwait) begin
            rd_addr = {r_bank, (r_mode == sket_pkg::MODE_READ) ? idx_ext[AW-1:0] : AW'(0)};
        end else if (i_cmd.step && consume) begin
            rd_addr = {r_bank, k_inc[AW-1:0]};
        end else begin
            rd_addr = {r_bank, (r_mode == sket_pkg::MODE_READ) ? idx_ext[AW-1:0]
                                                               : r_k[AW-1:0]};
        end
    end
    assign wr_addr = {~r_bank, r_w[AW-1:0]};

    always_ff @(posedge i_clk) begin
        r_rd_pos <= mem_pos[rd_addr];
        r_rd_hgt <= mem_hgt[rd_addr];
        if (i_cmd.step && emit && (r_w < (CW+1)'(MAX_EDGES))) begin
            mem_pos[wr_addr] <= e_pos;
            mem_hgt[wr_addr] <= e_hgt;
        end
    end

    // result of the finished item
    always_comb begin
        o_res_pos    = '0;
        o_res_height = '0;
        o_res_count  = r_count;
        o_res_status = sket_pkg::ST_OK;
        unique case (r_mode)
            sket_pkg::MODE_ADD: begin
                if (!o_stat.add_go) begin
                    o_res_status = sket_pkg::ST_EMPTY;
                end else if (!fits) begin
                    o_res_status = sket_pkg::ST_FULL;
                end else begin
                    o_res_count = r_w[CW-1:0];
                end
            end
            sket_pkg::MODE_READ: begin
                if (idx_ok) begin
                    o_res_pos    = r_rd_pos;
                    o_res_height = r_rd_hgt;
                end else begin
                    o_res_status = sket_pkg::ST_RANGE;
                end
            end
            sket_pkg::MODE_CLEAR: o_res_count = '0;
            default: o_res_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_bank  <= 1'b0;
        end else if (i_cmd.finish) begin
            r_count <= o_res_count;
            if (r_mode == sket_pkg::MODE_ADD && o_stat.add_go && fits) begin
                r_bank <= ~r_bank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode       <= i_mode;
            r_x1         <= i_left_x;
            r_x2         <= i_right_x;
            r_h          <= i_height;
            r_index      <= i_index;
            r_k          <= '0;
            r_w          <= '0;
            r_ins        <= '0;
            r_left_done  <= 1'b0;
            r_right_done <= 1'b0;
            r_inreg      <= 1'b0;
            r_prevh      <= '0;
            r_lasth      <= '0;
            r_have_last  <= 1'b0;
        end else if (i_cmd.step) begin
            r_k          <= n_k;
            r_w          <= n_w;
            r_ins        <= n_ins;
            r_left_done  <= n_left_done;
            r_right_done <= n_right_done;
            r_inreg      <= n_inreg;
            r_prevh      <= n_prevh;
            r_lasth      <= n_lasth;
            r_have_last  <= n_have_last;
        end
    end

    a_w_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> r_w <= (CW+1)'(r_count) + (CW+1)'(r_ins))
        else $error("sket_dp: more edges written than read plus inserted");
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> r_k <= r_count) else $error("sket_dp: scan ran past table end");
    a_bank_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.finish |=> $stable(r_bank)) else $error("sket_dp: bank swapped mid item");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && r_right_done) |-> r_left_done)
        else $error("sket_dp: right edge placed before left edge");

endmodule

[hdl/skyline_edge_table.sv]
// ----------------------------------------------------------------------------
// skyline_edge_table
// Sorted table of skyline edges: add a building, read an edge, clear.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_mode i_left_x i_right_x
//          |           |                            | i_height i_index
//  out     | output    | o_out_valid / i_out_ready  | o_edge_pos o_edge_height
//          |           |                            | o_edge_count o_status
//
// An add scans the old table: one old edge is read from the single-read-port
// store per scan cycle, and the left and right edge markers take a scan step
// each (the left one shares its step with the old edge already at left_x);
// read, clear and ignored adds skip the scan.
// One item is in work at a time; the next transfer is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// Reset (synchronous, active low) empties the table at once; no clearing pass.
// A stalled output holds the result and delays only the following item.
//
module skyline_edge_table #(
    parameter int MAX_EDGES   = sket_pkg::MAX_EDGES_DEF,
    parameter int COORD_BITS  = sket_pkg::COORD_BITS_DEF,
    parameter int HEIGHT_BITS = sket_pkg::HEIGHT_BITS_DEF,
    localparam int CW = $clog2(MAX_EDGES + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_mode,
    input  logic signed [COORD_BITS-1:0]    i_left_x,
    input  logic signed [COORD_BITS-1:0]    i_right_x,
    input  logic [HEIGHT_BITS-1:0]          i_height,
    input  logic [sket_pkg::INDEX_BITS-1:0] i_index,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [COORD_BITS-1:0]    o_edge_pos,
    output logic [HEIGHT_BITS-1:0]          o_edge_height,
    output logic [CW-1:0]                   o_edge_count,
    output logic [1:0]                      o_status
);

    sket_pkg::t_cmd  cmd;
    sket_pkg::t_stat stat;
    logic            out_free;

    logic signed [COORD_BITS-1:0] res_pos;
    logic [HEIGHT_BITS-1:0]       res_height;
    logic [CW-1:0]                res_count;
    logic [1:0]                   res_status;

    logic                         r_out_valid;
    logic signed [COORD_BITS-1:0] r_edge_pos;
    logic [HEIGHT_BITS-1:0]       r_edge_height;
    logic [CW-1:0]                r_edge_count;
    logic [1:0]                   r_status;

    // output slot is free when empty or being drained this cycle
    assign out_free = !r_out_valid || i_out_ready;

    sket_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sket_dp #(
        .MAX_EDGES   (MAX_EDGES),
        .COORD_BITS  (COORD_BITS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_mode       (i_mode),
        .i_left_x     (i_left_x),
        .i_right_x    (i_right_x),
        .i_height     (i_height),
        .i_index      (i_index),
        .o_res_pos    (res_pos),
        .o_res_height (res_height),
        .o_res_count  (res_count),
        .o_res_status (res_status)
    );

    // output register: load on finish, drop valid once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.finish) begin
            r_edge_pos    <= res_pos;
            r_edge_height <= res_height;
            r_edge_count  <= res_count;
            r_status      <= res_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_edge_pos    = r_edge_pos;
    assign o_edge_height = r_edge_height;
    assign o_edge_count  = r_edge_count;
    assign o_status      = r_status;

endmodule

[bench/skyline_edge_table_checker.sv]
// ----------------------------------------------------------------------------
// skyline_edge_table_checker
// Watches both channels, predicts each result, compares field by field.
// ----------------------------------------------------------------------------
module skyline_edge_table_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_left_x,
    input  logic signed [31:0] i_right_x,
    input  logic [15:0]        i_height,
    input  logic [5:0]         i_index,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_edge_pos,
    input  logic [15:0]        i_edge_height,
    input  logic [6:0]         i_edge_count,
    input  logic [1:0]         i_status,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic signed [31:0] pos;
        logic [15:0]        hgt;
        logic [6:0]         cnt;
        logic [1:0]         st;
    } t_edge_result;

    // model copy of the outline table
    logic signed [31:0] sky_x [0:64];
    logic [15:0]        sky_h [0:64];
    int                 sky_n;
    t_edge_result       awaited_q[$];

    assign o_pending = awaited_q.size();

    initial o_errors = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    function automatic void open_slot(input int at, input logic signed [31:0] x,
                                      input logic [15:0] h);
        for (int k = sky_n; k > at; k--) begin
            sky_x[k] = sky_x[k-1];
            sky_h[k] = sky_h[k-1];
        end
        sky_x[at] = x;
        sky_h[at] = h;
        sky_n++;
    endfunction

    function automatic sket_pkg::t_status place_building(input logic signed [31:0] x1,
                                                         input logic signed [31:0] x2,
                                                         input logic [15:0] h);
        int n, i, j, r, l, w;
        bit rins, lins, seen;
        logic [15:0] rh, prevh, hh;
        n = sky_n; rh = 0; prevh = 0; seen = 0;
        if (x1 >= x2 || h == 0) return sket_pkg::ST_EMPTY;
        for (i = 0; i < n && sky_x[i] < x2; i++) ;
        if (i < n && sky_x[i] == x2) rins = 0;
        else if (i == n || i == 0) rins = 1;
        else begin
            rins = h > sky_h[i-1];
            rh = sky_h[i-1];
        end
        for (j = 0; j < n && sky_x[j] <= x1; j++) ;
        if (j == 0) lins = 1;
        else if (sky_x[j-1] == x1) lins = 0;
        else lins = h > sky_h[j-1];
        if (n + int'(rins) + int'(lins) > 64) return sket_pkg::ST_FULL;
        r = i;
        if (rins) open_slot(i, x2, rh);
        if (lins) begin
            open_slot(j, x1, h);
            l = j;
            r++;
        end else begin
            l = j - 1;
            if (sky_h[l] < h) sky_h[l] = h;
        end
        // raise the covered span and merge equal neighbors
        w = l;
        for (int k = l; k < r; k++) begin
            hh = sky_h[k] < h ? h : sky_h[k];
            if (!(seen && hh == prevh)) begin
                sky_x[w] = sky_x[k];
                sky_h[w] = hh;
                prevh = hh;
                seen = 1;
                w++;
            end
        end
        for (int k = r; k < sky_n; k++, w++) begin
            sky_x[w] = sky_x[k];
            sky_h[w] = sky_h[k];
        end
        sky_n = w;
        return sket_pkg::ST_OK;
    endfunction

    always @(posedge i_clk) begin
        t_edge_result e, g;
        if (!i_rst_n) begin
            sky_n = 0;
            awaited_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                g = '{i_edge_pos, i_edge_height, i_edge_count, i_status};
                if (awaited_q.size() == 0) begin
                    report("unexpected transfer", 64'(g), 0);
                end else begin
                    e = awaited_q.pop_front();
                    if (g.pos !== e.pos) report("edge_pos", 64'(g.pos), 64'(e.pos));
                    if (g.hgt !== e.hgt) report("edge_height", 64'(g.hgt), 64'(e.hgt));
                    if (g.cnt !== e.cnt) report("edge_count", 64'(g.cnt), 64'(e.cnt));
                    if (g.st !== e.st) report("status", 64'(g.st), 64'(e.st));
                end
            end
            if (i_in_valid && i_in_ready) begin
                e = '0;
                case (sket_pkg::t_mode'(i_mode))
                    sket_pkg::MODE_ADD:
                        e.st = place_building(i_left_x, i_right_x, i_height);
                    sket_pkg::MODE_READ:
                        if (i_index < sky_n) begin
                            e.pos = sky_x[i_index];
                            e.hgt = sky_h[i_index];
                        end else begin
                            e.st = sket_pkg::ST_RANGE;
                        end
                    sket_pkg::MODE_CLEAR: sky_n = 0;
                    default: ;
                endcase
                e.cnt = 7'(sky_n);
                awaited_q.push_back(e);
            end
        end
    end

endmodule

[bench/skyline_edge_table_test.sv]
// ----------------------------------------------------------------------------
// skyline_edge_table_test
// Directed and random buildings, reads and clears against a checker.
// ----------------------------------------------------------------------------
module skyline_edge_table_test;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               in_valid = 0;
    logic               in_ready;
    logic [1:0]         mode = sket_pkg::MODE_NONE;
    logic signed [31:0] left_x = 0;
    logic signed [31:0] right_x = 0;
    logic [15:0]        height = 0;
    logic [5:0]         index = 0;
    logic               out_valid;
    logic               out_ready = 0;
    logic signed [31:0] edge_pos;
    logic [15:0]        edge_height;
    logic [6:0]         edge_count;
    logic [1:0]         status;
    int                 errors, pending;
    bit                 calm = 0;     // no idling on either side while set
    int                 hold_off = 0; // receiver stall, counted in cycles

    always #5 i_clk = ~i_clk;

    skyline_edge_table u_dut (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_mode(mode), .i_left_x(left_x), .i_right_x(right_x),
        .i_height(height), .i_index(index),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_edge_pos(edge_pos), .o_edge_height(edge_height),
        .o_edge_count(edge_count), .o_status(status)
    );

    skyline_edge_table_checker u_check (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_mode(mode), .i_left_x(left_x), .i_right_x(right_x),
        .i_height(height), .i_index(index),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_edge_pos(edge_pos), .i_edge_height(edge_height),
        .i_edge_count(edge_count), .i_status(status),
        .o_errors(errors), .o_pending(pending)
    );

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ready <= 0;
        end else begin
            out_ready <= calm || ($urandom_range(99) >= 24);
        end
    end

    // Offer one transfer; hold valid and payload until it is taken.
    task automatic send(input logic [1:0] m, input logic signed [31:0] x1,
                        input logic signed [31:0] x2, input logic [15:0] h,
                        input logic [5:0] ix);
        while (!calm && $urandom_range(99) < 24) begin
            in_valid <= 0;
            @(posedge i_clk);
        end
        in_valid <= 1;
        mode <= m; left_x <= x1; right_x <= x2; height <= h; index <= ix;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic idle_line();
        in_valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_x(input int span);
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'sh7fffffff - $urandom_range(3);
            2: return 32'sh80000000 + $urandom_range(3);
            default: return $signed($urandom_range(2 * span)) - span;
        endcase
    endfunction

    // Random building over a small x range, so edges collide and merge.
    task automatic random_add(input int span);
        logic signed [31:0] a, b;
        a = pick_x(span);
        b = ($urandom_range(9) == 0) ? pick_x(span) : a + $urandom_range(span);
        send(sket_pkg::MODE_ADD, a, b,
             ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12)), $urandom);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reads of an empty table, empty buildings, extremes
        send(sket_pkg::MODE_READ, 0, 0, 0, 0);
        send(sket_pkg::MODE_NONE, $urandom, $urandom, $urandom, $urandom);
        send(sket_pkg::MODE_ADD, 5, 5, 7, 0);
        send(sket_pkg::MODE_ADD, 9, 5, 7, 0);
        send(sket_pkg::MODE_ADD, 0, 10, 0, 0);
        send(sket_pkg::MODE_ADD, 32'sh80000000, 32'sh7fffffff, 16'hffff, 0);
        send(sket_pkg::MODE_ADD, 0, 10, 16'h0001, 0);
        send(sket_pkg::MODE_ADD, 32'sh80000000, 0, 16'h8000, 0);
        send(sket_pkg::MODE_ADD, 10, 32'sh7fffffff, 3, 0);
        send(sket_pkg::MODE_ADD, -20, 20, 2, 0);
        send(sket_pkg::MODE_ADD, 0, 5, 16'hffff, 0);
        for (int k = 0; k < 8; k++) send(sket_pkg::MODE_READ, 0, 0, 0, 6'(k));
        send(sket_pkg::MODE_READ, 0, 0, 0, 6'h3f);
        send(sket_pkg::MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
        send(sket_pkg::MODE_READ, 0, 0, 0, 0);

        // fill the table with disjoint steps until it reports full
        for (int k = 0; k < 40; k++)
            send(sket_pkg::MODE_ADD, 10 * k, 10 * k + 5, 16'(k + 1), 0);
        for (int k = 0; k < 4; k++)
            send(sket_pkg::MODE_READ, 0, 0, 0, 6'($urandom_range(60, 63)));
        send(sket_pkg::MODE_CLEAR, 0, 0, 0, 0);

        // random, with a calm stretch and pressure in between
        for (int k = 0; k < 640; k++) begin
            if (k == 200) calm = 1;
            if (k == 300) calm = 0;
            if (k == 350) hold_off = 300;
            if (k == 450) begin
                idle_line();
                wait (pending == 0);
            end
            case ($urandom_range(19))
                0: send(sket_pkg::MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
                1: send(sket_pkg::MODE_NONE, $urandom, $urandom, $urandom, $urandom);
                2, 3, 4, 5:
                    send(sket_pkg::MODE_READ, $urandom, $urandom, $urandom,
                         $urandom_range(63));
                default: random_add((k % 160 < 80) ? 40 : 1000);
            endcase
        end
        idle_line();
        calm = 1;
        wait (pending == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

endmodule

[skyline_edge_table.f]
hdl/sket_pkg.sv
hdl/sket_ctrl.sv
hdl/sket_dp.sv
hdl/skyline_edge_table.sv
bench/skyline_edge_table_checker.sv
bench/skyline_edge_table_test.sv
